>>> rtl/core/decas_pkg.sv
// decas_pkg: shared constants, action codes and controller/datapath
// command and status types for the decimal add/subtract core
// no dependencies
package decas_pkg;

    // operand capacity in digits
    localparam int MAX_DIGITS = 32;
    localparam int DIGIT_W    = 4;
    localparam int DIGIT_MAX  = 9;
    localparam int DEC_BASE   = 10;

    // digit counts hold 0..MAX_DIGITS, positions 0..MAX_DIGITS+1
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W    = $clog2(MAX_DIGITS);
    localparam int POS_W     = $clog2(MAX_DIGITS + 2);
    localparam int BUF_DEPTH = MAX_DIGITS + 1;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    localparam int ACTION_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_ADD    = 2'd2,
        ACT_SUB    = 2'd3
    } action_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // store one operand digit
        logic init;       // start a compute
        logic init_top;   // start at the top digit (magnitude compare)
        logic add_step;   // one digit of addition
        logic add_carry;  // write the final carry digit
        logic cmp_step;   // one digit of magnitude compare
        logic sub_step;   // one digit of subtraction
        logic emit_init;  // point at the most significant result digit
        logic out_sign;   // load the minus item into the output register
        logic out_digit;  // load one result digit into the output register
        logic finish;     // clear operand counts and drop flag
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic len_eq;       // operands have the same effective length
        logic last_pos;     // current position is the top digit
        logic add_carry;    // this addition step carries out
        logic cmp_decided;  // compare reached a differing digit or the bottom
        logic pos_zero;     // emission reached the least significant digit
        logic out_free;     // output register can take an item this cycle
        logic neg;          // subtract result is negative
    } sts_t;

endpackage

>>> rtl/core/decas_in_if.sv
// decas_in_if: input channel of the decimal add/subtract core
// depends on decas_pkg
interface decas_in_if;
    logic                              valid;
    logic                              ready;
    logic [decas_pkg::ACTION_W-1:0]    action;
    logic [decas_pkg::DIGIT_W-1:0]     digit;

    modport source (output valid, output action, output digit, input ready);
    modport sink   (input valid, input action, input digit, output ready);
endinterface

>>> rtl/core/decas_out_if.sv
// decas_out_if: result channel of the decimal add/subtract core
// depends on decas_pkg
interface decas_out_if;
    logic                              valid;
    logic                              ready;
    logic [decas_pkg::DIGIT_W-1:0]     digit_out;
    logic                              minus_sign;
    logic                              last_out;
    logic                              overflow_flag;

    modport source (output valid, output digit_out, output minus_sign,
                    output last_out, output overflow_flag, input ready);
    modport sink   (input valid, input digit_out, input minus_sign,
                    input last_out, input overflow_flag, output ready);
endinterface

>>> rtl/core/decas_ram.sv
// decas_ram: generic single write port, single read port ram with
// registered read data; no dependencies
module decas_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/decas_dp.sv
// decas_dp: datapath of the decimal add/subtract core: operand stores,
// result buffer, digit arithmetic and output register
// depends on decas_pkg and decas_ram
module decas_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [decas_pkg::ACTION_W-1:0]    in_action,
    input  logic [decas_pkg::DIGIT_W-1:0]     in_digit,
    input  decas_pkg::cmd_t                   cmd,
    output decas_pkg::sts_t                   sts,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [decas_pkg::DIGIT_W-1:0]     out_digit,
    output logic                              out_minus,
    output logic                              out_last,
    output logic                              out_ovf
);

    localparam int DW = decas_pkg::DIGIT_W;
    localparam int PW = decas_pkg::POS_W;
    localparam int CW = decas_pkg::CNT_W;
    localparam int AW = decas_pkg::ADDR_W;
    localparam int BW = decas_pkg::BUF_AW;

    logic [CW-1:0] first_count_reg, first_count_next;
    logic [CW-1:0] second_count_reg, second_count_next;
    logic          dropped_reg, dropped_next;

    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] len_reg, len_next;
    logic [PW-1:0] nz_reg, nz_next;
    logic          carry_reg, carry_next;
    logic          neg_reg, neg_next;
    logic          sub_reg, sub_next;

    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_digit_reg, out_digit_next;
    logic          out_minus_reg, out_minus_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    logic [DW-1:0] load_digit;
    logic          is_load_a;
    logic          is_load_b;
    logic          is_sub;
    logic          a_we;
    logic          b_we;
    logic [AW-1:0] a_waddr;
    logic [AW-1:0] b_waddr;
    logic [PW-1:0] a_rtmp;
    logic [PW-1:0] b_rtmp;
    logic [DW-1:0] a_rdata;
    logic [DW-1:0] b_rdata;
    logic [DW-1:0] a_val;
    logic [DW-1:0] b_val;
    logic [PW-1:0] eff_a;
    logic [PW-1:0] eff_b;
    logic [PW-1:0] len_max;

    logic [DW:0]   sum5;
    logic          sum_ge;
    logic [DW-1:0] sum_digit;
    logic [DW-1:0] x_val;
    logic [DW-1:0] y_val;
    logic [DW:0]   sub5;
    logic          sub_lt;
    logic [DW:0]   diff5;
    logic [DW-1:0] diff_digit;

    logic          buf_we;
    logic [DW-1:0] buf_wdata;
    logic [DW-1:0] buf_rdata;
    logic          out_free;

    // load digit clamp and action decode
    assign load_digit = (in_digit > DW'(decas_pkg::DIGIT_MAX))
                        ? DW'(decas_pkg::DIGIT_MAX) : in_digit;
    assign is_load_a  = (in_action == decas_pkg::ACT_LOAD_A);
    assign is_load_b  = (in_action == decas_pkg::ACT_LOAD_B);
    assign is_sub     = (in_action == decas_pkg::ACT_SUB);

    // operand store write side
    assign a_we    = cmd.load && is_load_a
                     && (first_count_reg < CW'(decas_pkg::MAX_DIGITS));
    assign b_we    = cmd.load && is_load_b
                     && (second_count_reg < CW'(decas_pkg::MAX_DIGITS));
    assign a_waddr = first_count_reg[AW-1:0];
    assign b_waddr = second_count_reg[AW-1:0];

    // operand read address: digit pos counted from the least significant end
    assign a_rtmp = PW'(first_count_reg) - PW'(1) - pos_reg;
    assign b_rtmp = PW'(second_count_reg) - PW'(1) - pos_reg;

    decas_ram #(
        .WIDTH (DW),
        .DEPTH (decas_pkg::MAX_DIGITS)
    ) u_first_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (load_digit),
        .raddr (a_rtmp[AW-1:0]),
        .rdata (a_rdata)
    );

    decas_ram #(
        .WIDTH (DW),
        .DEPTH (decas_pkg::MAX_DIGITS)
    ) u_second_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (load_digit),
        .raddr (b_rtmp[AW-1:0]),
        .rdata (b_rdata)
    );

    // digits beyond an operand's length read as zero
    assign a_val = (PW'(first_count_reg) > pos_reg) ? a_rdata : '0;
    assign b_val = (PW'(second_count_reg) > pos_reg) ? b_rdata : '0;

    // effective lengths, empty operand counts as one zero digit
    assign eff_a   = (first_count_reg == '0) ? PW'(1) : PW'(first_count_reg);
    assign eff_b   = (second_count_reg == '0) ? PW'(1) : PW'(second_count_reg);
    assign len_max = (eff_a > eff_b) ? eff_a : eff_b;

    // decimal add digit
    assign sum5      = {1'b0, a_val} + {1'b0, b_val} + {{DW{1'b0}}, carry_reg};
    assign sum_ge    = (sum5 >= (DW+1)'(decas_pkg::DEC_BASE));
    assign sum_digit = sum_ge ? DW'(sum5 - (DW+1)'(decas_pkg::DEC_BASE)) : sum5[DW-1:0];

    // decimal subtract digit, operands swapped when the result is negative
    assign x_val      = neg_reg ? b_val : a_val;
    assign y_val      = neg_reg ? a_val : b_val;
    assign sub5       = {1'b0, y_val} + {{DW{1'b0}}, carry_reg};
    assign sub_lt     = ({1'b0, x_val} < sub5);
    assign diff5      = sub_lt ? ({1'b0, x_val} + (DW+1)'(decas_pkg::DEC_BASE) - sub5)
                               : ({1'b0, x_val} - sub5);
    assign diff_digit = diff5[DW-1:0];

    // result buffer, least significant digit at address zero
    assign buf_we = cmd.add_step || cmd.sub_step || cmd.add_carry;

    always_comb
    begin
        priority if (cmd.add_step)
        begin
            buf_wdata = sum_digit;
        end
        else if (cmd.sub_step)
        begin
            buf_wdata = diff_digit;
        end
        else
        begin
            buf_wdata = DW'(1);
        end
    end

    decas_ram #(
        .WIDTH (DW),
        .DEPTH (decas_pkg::BUF_DEPTH)
    ) u_result_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (pos_reg[BW-1:0]),
        .wdata (buf_wdata),
        .raddr (pos_reg[BW-1:0]),
        .rdata (buf_rdata)
    );

    // operand counts and drop flag
    always_comb
    begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        dropped_next      = dropped_reg;
        if (cmd.load)
        begin
            if (is_load_a)
            begin
                if (a_we)
                begin
                    first_count_next = first_count_reg + CW'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end
            if (is_load_b)
            begin
                if (b_we)
                begin
                    second_count_next = second_count_reg + CW'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end
        end
        if (cmd.finish)
        begin
            first_count_next  = '0;
            second_count_next = '0;
            dropped_next      = 1'b0;
        end
    end

    // position, carry, sign and nonzero tracking
    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        nz_next    = nz_reg;
        carry_next = carry_reg;
        neg_next   = neg_reg;
        sub_next   = sub_reg;
        if (cmd.init)
        begin
            pos_next   = cmd.init_top ? (len_max - PW'(1)) : '0;
            len_next   = len_max;
            nz_next    = '0;
            carry_next = 1'b0;
            neg_next   = is_sub && (eff_a < eff_b);
            sub_next   = is_sub;
        end
        if (cmd.add_step)
        begin
            carry_next = sum_ge;
            pos_next   = pos_reg + PW'(1);
        end
        if (cmd.cmp_step)
        begin
            if (a_val != b_val)
            begin
                neg_next = (a_val < b_val);
            end
            pos_next = sts.cmp_decided ? '0 : (pos_reg - PW'(1));
        end
        if (cmd.sub_step)
        begin
            carry_next = sub_lt;
            if (diff_digit != '0)
            begin
                nz_next = pos_reg + PW'(1);
            end
            pos_next = pos_reg + PW'(1);
        end
        if (cmd.emit_init)
        begin
            if (sub_reg)
            begin
                pos_next = (nz_reg == '0) ? '0 : (nz_reg - PW'(1));
            end
            else
            begin
                pos_next = carry_reg ? pos_reg : (pos_reg - PW'(1));
            end
        end
        if (cmd.out_digit && (pos_reg != '0))
        begin
            pos_next = pos_reg - PW'(1);
        end
    end

    // output register, refilled in the cycle it is taken
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_digit_next = out_digit_reg;
        out_minus_next = out_minus_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_sign)
        begin
            out_valid_next = 1'b1;
            out_digit_next = '0;
            out_minus_next = 1'b1;
            out_last_next  = 1'b0;
            out_ovf_next   = dropped_reg;
        end
        if (cmd.out_digit)
        begin
            out_valid_next = 1'b1;
            out_digit_next = buf_rdata;
            out_minus_next = 1'b0;
            out_last_next  = (pos_reg == '0);
            out_ovf_next   = dropped_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            dropped_reg      <= dropped_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        len_reg       <= len_next;
        nz_reg        <= nz_next;
        carry_reg     <= carry_next;
        neg_reg       <= neg_next;
        sub_reg       <= sub_next;
        out_digit_reg <= out_digit_next;
        out_minus_reg <= out_minus_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // status to the controller
    assign sts.len_eq      = (eff_a == eff_b);
    assign sts.last_pos    = (pos_reg == (len_reg - PW'(1)));
    assign sts.add_carry   = sum_ge;
    assign sts.cmp_decided = (a_val != b_val) || (pos_reg == '0);
    assign sts.pos_zero    = (pos_reg == '0);
    assign sts.out_free    = out_free;
    assign sts.neg         = neg_reg;

    assign out_valid = out_valid_reg;
    assign out_digit = out_digit_reg;
    assign out_minus = out_minus_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

    // operand counts stay within capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (first_count_reg <= CW'(decas_pkg::MAX_DIGITS))
        && (second_count_reg <= CW'(decas_pkg::MAX_DIGITS)))
        else $error("operand count beyond capacity");

    // a result is never loaded over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_sign || cmd.out_digit) |-> out_free)
        else $error("output register overwritten");

    // emission reads inside the result buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_digit |-> (pos_reg <= PW'(decas_pkg::MAX_DIGITS)))
        else $error("result position out of range");

    // a finished compute leaves empty operands behind
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> ((first_count_reg == '0) && (second_count_reg == '0)
                        && !dropped_reg))
        else $error("operands not cleared after compute");

endmodule

>>> rtl/core/decas_ctrl.sv
// decas_ctrl: sequencing state machine of the decimal add/subtract core
// depends on decas_pkg
module decas_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [decas_pkg::ACTION_W-1:0]    in_action,
    output logic                              in_ready,
    output decas_pkg::cmd_t                   cmd,
    input  decas_pkg::sts_t                   sts
);

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_ADD_RD    = 12'b0000_0000_0010,
        ST_ADD_EX    = 12'b0000_0000_0100,
        ST_ADD_CY    = 12'b0000_0000_1000,
        ST_CMP_RD    = 12'b0000_0001_0000,
        ST_CMP_EX    = 12'b0000_0010_0000,
        ST_SUB_RD    = 12'b0000_0100_0000,
        ST_SUB_EX    = 12'b0000_1000_0000,
        ST_PREP      = 12'b0001_0000_0000,
        ST_EMIT_SIGN = 12'b0010_0000_0000,
        ST_EMIT_RD   = 12'b0100_0000_0000,
        ST_EMIT_EX   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (decas_pkg::action_t'(in_action))
                        decas_pkg::ACT_LOAD_A, decas_pkg::ACT_LOAD_B:
                        begin
                            cmd.load = 1'b1;
                        end
                        decas_pkg::ACT_ADD:
                        begin
                            cmd.init   = 1'b1;
                            state_next = ST_ADD_RD;
                        end
                        decas_pkg::ACT_SUB:
                        begin
                            cmd.init     = 1'b1;
                            cmd.init_top = sts.len_eq;
                            state_next   = sts.len_eq ? ST_CMP_RD : ST_SUB_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                state_next = ST_ADD_EX;
            end
            ST_ADD_EX:
            begin
                cmd.add_step = 1'b1;
                if (sts.last_pos)
                begin
                    state_next = sts.add_carry ? ST_ADD_CY : ST_PREP;
                end
                else
                begin
                    state_next = ST_ADD_RD;
                end
            end
            ST_ADD_CY:
            begin
                cmd.add_carry = 1'b1;
                state_next    = ST_PREP;
            end
            ST_CMP_RD:
            begin
                state_next = ST_CMP_EX;
            end
            ST_CMP_EX:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = sts.cmp_decided ? ST_SUB_RD : ST_CMP_RD;
            end
            ST_SUB_RD:
            begin
                state_next = ST_SUB_EX;
            end
            ST_SUB_EX:
            begin
                cmd.sub_step = 1'b1;
                state_next   = sts.last_pos ? ST_PREP : ST_SUB_RD;
            end
            ST_PREP:
            begin
                cmd.emit_init = 1'b1;
                state_next    = sts.neg ? ST_EMIT_SIGN : ST_EMIT_RD;
            end
            ST_EMIT_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_sign = 1'b1;
                    state_next   = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_EX;
            end
            ST_EMIT_EX:
            begin
                if (sts.out_free)
                begin
                    cmd.out_digit = 1'b1;
                    if (sts.pos_zero)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // the minus item is only sent for a negative difference
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_sign |-> sts.neg)
        else $error("minus item for a non-negative result");

    // a compute ends only on its least significant digit
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (cmd.out_digit && sts.pos_zero))
        else $error("compute finished before its last digit");

endmodule

>>> rtl/core/decimal_add_subtract_core.sv
// decimal_add_subtract_core: top level of the decimal add/subtract block
// depends on decas_pkg, decas_in_if, decas_out_if, decas_ctrl, decas_dp
//
// usage
//   din carries one transaction per action: load a digit of the first or
//   second operand (most significant first), or compute add / subtract.
//   digits above nine load as nine; digits past capacity are dropped and
//   reported through overflow_flag on every result of the next compute.
//   dout carries the answer, most significant digit first, with an
//   optional leading minus transaction and last_out on the final digit.
// sequence
//   a load is taken while idle. a compute walks the operand stores
//   through their single read ports, with a read state and an execute
//   state per digit: one pass of length L (the longer operand) for add,
//   plus up to L more for the magnitude compare of a subtract with equal
//   lengths, then a read and an execute state per result digit to read
//   the result buffer back, with an extra state for a final carry or a
//   minus transaction. din is not ready during a compute.
// reset and stall
//   reset empties both operands and the output register; no clearing
//   pass is needed. a stalled dout holds its transaction and the walk
//   waits; loads are taken again once the final digit is registered.
module decimal_add_subtract_core (
    input  logic         clk,
    input  logic         rst_n,
    decas_in_if.sink     din,
    decas_out_if.source  dout
);

    decas_pkg::cmd_t cmd;
    decas_pkg::sts_t sts;

    decas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_action (din.action),
        .in_ready  (din.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    decas_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_action (din.action),
        .in_digit  (din.digit),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (dout.ready),
        .out_valid (dout.valid),
        .out_digit (dout.digit_out),
        .out_minus (dout.minus_sign),
        .out_last  (dout.last_out),
        .out_ovf   (dout.overflow_flag)
    );

endmodule

>>> bench/tb_decimal_add_subtract_core.sv
// tb_decimal_add_subtract_core: self-checking bench for the decimal add/subtract core
// depends on decas_pkg, decas_in_if, decas_out_if and decimal_add_subtract_core
// digit loads and computes go in, every answer digit is checked against a local model
module tb_decimal_add_subtract_core;

    localparam int RANDOM_ITEMS = 270;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;

    typedef logic [decas_pkg::MAX_DIGITS-1:0][decas_pkg::DIGIT_W-1:0] digit_store_t;

    // one input transaction waiting to be sent
    typedef struct {
        decas_pkg::action_t              act;
        logic [decas_pkg::DIGIT_W-1:0]   digit;
        bit                              drain_first;
    } digit_op_t;

    // one answer transaction as the block should produce it
    typedef struct packed {
        logic [decas_pkg::DIGIT_W-1:0]   digit;
        logic                            minus;
        logic                            last_item;
        logic                            overflow;
    } answer_t;

    logic clk;
    logic rst_n = 1'b0;

    // tb-side copies of the block's inputs, known from time zero
    logic                            in_valid  = 1'b0;
    decas_pkg::action_t              in_action = decas_pkg::ACT_LOAD_A;
    logic [decas_pkg::DIGIT_W-1:0]   in_digit  = '0;
    logic                            res_ready = 1'b0;

    decas_in_if  din_bus();
    decas_out_if dout_bus();

    assign din_bus.valid  = in_valid;
    assign din_bus.action = in_action;
    assign din_bus.digit  = in_digit;
    assign dout_bus.ready = res_ready;

    decimal_add_subtract_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_bus),
        .dout  (dout_bus)
    );

    digit_op_t    action_q[$];
    answer_t      answer_q[$];

    // local model state
    digit_store_t first_digits;
    digit_store_t second_digits;
    int unsigned  first_cnt;
    int unsigned  second_cnt;
    bit           digits_dropped;

    int unsigned  send_gap;
    int unsigned  recv_gap;
    int unsigned  calm_left;
    int unsigned  idle_cycles;
    int unsigned  items_total;
    int unsigned  items_sent;
    int unsigned  results_seen;
    int unsigned  adds_done;
    int unsigned  subs_done;
    int unsigned  negatives_seen;
    int unsigned  overflow_computes;
    int unsigned  fail_count;
    digit_op_t    next_op;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length for either side: mostly short, a few long, with calm stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 2)
        begin
            calm_left = $urandom_range(60, 20);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // digit at a position counted from the least significant end
    function automatic int unsigned digit_from_low(digit_store_t store, int unsigned cnt,
                                                   int unsigned pos);
        if (pos >= cnt)
            return 0;
        return int'(store[cnt - 1 - pos]);
    endfunction

    function automatic int unsigned padded_len(int unsigned cnt);
        return (cnt == 0) ? 1 : cnt;
    endfunction

    function automatic void push_answer(int unsigned digit, bit minus, bit last_item);
        answer_t ans;
        ans.digit     = digit[decas_pkg::DIGIT_W-1:0];
        ans.minus     = minus;
        ans.last_item = last_item;
        ans.overflow  = digits_dropped;
        answer_q.push_back(ans);
    endfunction

    // apply one accepted transaction to the local model and queue its answer digits
    function automatic void predict_decimal_op(decas_pkg::action_t act,
                                               logic [decas_pkg::DIGIT_W-1:0] raw);
        int unsigned  dv;
        int unsigned  cnt_a;
        int unsigned  cnt_b;
        int unsigned  len_a;
        int unsigned  len_b;
        int unsigned  n;
        int unsigned  p;
        int unsigned  carry;
        int unsigned  borrow;
        int unsigned  s;
        int unsigned  x;
        int unsigned  y;
        int unsigned  t;
        int unsigned  rev[decas_pkg::MAX_DIGITS+1];
        digit_store_t sa;
        digit_store_t sb;
        digit_store_t ts;
        bit           negative;
        bit           decided;

        dv = (int'(raw) > decas_pkg::DIGIT_MAX) ? decas_pkg::DIGIT_MAX : int'(raw);

        // loads only fill a store or set the dropped flag
        if (act == decas_pkg::ACT_LOAD_A)
        begin
            if (first_cnt < decas_pkg::MAX_DIGITS)
            begin
                first_digits[first_cnt] = dv[decas_pkg::DIGIT_W-1:0];
                first_cnt++;
            end
            else
                digits_dropped = 1'b1;
            return;
        end
        if (act == decas_pkg::ACT_LOAD_B)
        begin
            if (second_cnt < decas_pkg::MAX_DIGITS)
            begin
                second_digits[second_cnt] = dv[decas_pkg::DIGIT_W-1:0];
                second_cnt++;
            end
            else
                digits_dropped = 1'b1;
            return;
        end

        sa = first_digits;
        sb = second_digits;
        cnt_a = first_cnt;
        cnt_b = second_cnt;
        len_a = padded_len(cnt_a);
        len_b = padded_len(cnt_b);
        n = 0;
        negative = 1'b0;
        if (digits_dropped)
            overflow_computes++;

        if (act == decas_pkg::ACT_ADD)
        begin
            // ripple add keeping leading zeros, extra digit on final carry
            adds_done++;
            carry = 0;
            t = (len_a > len_b) ? len_a : len_b;
            for (p = 0; p < t; p++)
            begin
                s = digit_from_low(sa, cnt_a, p) + digit_from_low(sb, cnt_b, p) + carry;
                rev[n] = s % decas_pkg::DEC_BASE;
                n++;
                carry = s / decas_pkg::DEC_BASE;
            end
            if (carry != 0)
            begin
                rev[n] = 1;
                n++;
            end
        end
        else
        begin
            subs_done++;
            // order by digit count, then from the top digit down
            decided = 1'b0;
            if (len_a < len_b)
                negative = 1'b1;
            else if (len_a == len_b)
            begin
                for (p = len_a; p > 0 && !decided; p--)
                begin
                    x = digit_from_low(sa, cnt_a, p - 1);
                    y = digit_from_low(sb, cnt_b, p - 1);
                    if (x != y)
                    begin
                        negative = (x < y);
                        decided = 1'b1;
                    end
                end
            end
            if (negative)
            begin
                negatives_seen++;
                ts = sa;
                sa = sb;
                sb = ts;
                t = cnt_a;
                cnt_a = cnt_b;
                cnt_b = t;
                len_a = len_b;
            end
            // subtract with borrow; a borrow out of the top is dropped
            borrow = 0;
            for (p = 0; p < len_a; p++)
            begin
                y = digit_from_low(sb, cnt_b, p) + borrow;
                x = digit_from_low(sa, cnt_a, p);
                if (x < y)
                begin
                    rev[n] = x + decas_pkg::DEC_BASE - y;
                    borrow = 1;
                end
                else
                begin
                    rev[n] = x - y;
                    borrow = 0;
                end
                n++;
            end
            // strip leading zeros, keep one digit
            while (n > 1 && rev[n - 1] == 0)
                n--;
        end

        if (negative)
            push_answer(0, 1'b1, 1'b0);
        for (p = n; p > 0; p--)
            push_answer(rev[p - 1], 1'b0, p == 1);

        first_cnt = 0;
        second_cnt = 0;
        digits_dropped = 1'b0;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // stimulus building
    function automatic logic [decas_pkg::DIGIT_W-1:0] rand_digit();
        if ($urandom_range(99) < 90)
            return decas_pkg::DIGIT_W'($urandom_range(decas_pkg::DIGIT_MAX));
        return decas_pkg::DIGIT_W'($urandom_range(15, 10));
    endfunction

    function automatic int unsigned rand_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 70)
            return $urandom_range(5, 1);
        if (r < 88)
            return $urandom_range(12, 6);
        if (r < 97)
            return $urandom_range(decas_pkg::MAX_DIGITS, 13);
        return $urandom_range(decas_pkg::MAX_DIGITS + 4, decas_pkg::MAX_DIGITS + 1);
    endfunction

    task automatic queue_op(decas_pkg::action_t act, logic [decas_pkg::DIGIT_W-1:0] digit,
                            bit drain_first);
        digit_op_t op;
        op.act = act;
        op.digit = digit;
        op.drain_first = drain_first;
        action_q.push_back(op);
    endtask

    // one problem: load both operands in some order, then usually compute
    task automatic queue_random_problem(bit drain_first);
        int unsigned                     len_a;
        int unsigned                     len_b;
        int unsigned                     ia;
        int unsigned                     ib;
        int unsigned                     k;
        bit                              share;
        bit                              in_order;
        bit                              hold;
        bit                              take_a;
        logic [decas_pkg::DIGIT_W-1:0]   a_dig[$];
        logic [decas_pkg::DIGIT_W-1:0]   b_dig[$];

        hold = drain_first;
        // a little noise: a lone transaction of any kind
        if ($urandom_range(99) < 4)
        begin
            queue_op(decas_pkg::action_t'($urandom_range(3)),
                     decas_pkg::DIGIT_W'($urandom_range(15)), hold);
            return;
        end

        len_a = rand_length();
        len_b = ($urandom_range(99) < 40) ? len_a : rand_length();
        share = (len_a == len_b) && ($urandom_range(99) < 60);
        for (k = 0; k < len_a; k++)
            a_dig.push_back(rand_digit());
        for (k = 0; k < len_b; k++)
            b_dig.push_back(share ? a_dig[k] : rand_digit());
        // equal operands or ones that differ in a single digit stress the compare
        if (share && len_b > 0 && $urandom_range(1) == 1)
            b_dig[$urandom_range(len_b - 1)] = rand_digit();

        in_order = bit'($urandom_range(1));
        ia = 0;
        ib = 0;
        while (ia < len_a || ib < len_b)
        begin
            if (ib >= len_b)
                take_a = 1'b1;
            else if (ia >= len_a)
                take_a = 1'b0;
            else
                take_a = in_order ? 1'b1 : bit'($urandom_range(1));
            if (take_a)
            begin
                queue_op(decas_pkg::ACT_LOAD_A, a_dig[ia], hold);
                ia++;
            end
            else
            begin
                queue_op(decas_pkg::ACT_LOAD_B, b_dig[ib], hold);
                ib++;
            end
            hold = 1'b0;
        end

        // now and then leave the operands to pile up into the next problem
        if ($urandom_range(99) >= 5)
            queue_op($urandom_range(1) ? decas_pkg::ACT_ADD : decas_pkg::ACT_SUB,
                     rand_digit(), hold);
    endtask

    // driver: presents queued transactions, predicts each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_action <= decas_pkg::ACT_LOAD_A;
            in_digit  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (din_bus.valid && din_bus.ready)
            begin
                predict_decimal_op(decas_pkg::action_t'(din_bus.action), din_bus.digit);
                items_sent++;
                send_gap = pick_gap();
            end
            if (din_bus.valid && !din_bus.ready)
            begin
                // hold the transaction until it is taken
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (action_q.size() > 0 &&
                     !(action_q[0].drain_first && answer_q.size() > 0))
            begin
                next_op = action_q.pop_front();
                in_valid  <= 1'b1;
                in_action <= next_op.act;
                in_digit  <= next_op.digit;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: checks each answer transaction, stalls ready at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (dout_bus.valid && dout_bus.ready)
            begin
                results_seen++;
                if (answer_q.size() == 0)
                begin
                    $error("result transaction with no answer pending: digit_out=%0d minus=%0d",
                           dout_bus.digit_out, dout_bus.minus_sign);
                    fail_count++;
                end
                else
                begin
                    check_field("digit_out", answer_q[0].digit, dout_bus.digit_out);
                    check_field("minus_sign", answer_q[0].minus, dout_bus.minus_sign);
                    check_field("last_out", answer_q[0].last_item, dout_bus.last_out);
                    check_field("overflow_flag", answer_q[0].overflow, dout_bus.overflow_flag);
                    void'(answer_q.pop_front());
                end
                recv_gap = pick_gap();
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (din_bus.valid && din_bus.ready) || (dout_bus.valid && dout_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $error("no transaction for %0d cycles", STALL_LIMIT);
        $display("decimal_add_subtract_core test failed");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        int unsigned k;
        int unsigned directed_items;

        first_cnt = 0;
        second_cnt = 0;
        digits_dropped = 1'b0;
        first_digits = '0;
        second_digits = '0;
        calm_left = 0;
        idle_cycles = 0;
        items_sent = 0;
        results_seen = 0;
        adds_done = 0;
        subs_done = 0;
        negatives_seen = 0;
        overflow_computes = 0;
        fail_count = 0;

        // both operands empty, digit field ignored on computes
        queue_op(decas_pkg::ACT_ADD, 4'd0, 1'b0);
        queue_op(decas_pkg::ACT_SUB, 4'd15, 1'b0);
        // digits above nine load as nine: 9 + 9
        queue_op(decas_pkg::ACT_LOAD_A, 4'd15, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_B, 4'd9, 1'b0);
        queue_op(decas_pkg::ACT_ADD, 4'd0, 1'b0);
        // zero minus an empty operand
        queue_op(decas_pkg::ACT_LOAD_A, 4'd0, 1'b0);
        queue_op(decas_pkg::ACT_SUB, 4'd0, 1'b0);
        // empty minus 93 gives a minus sign
        queue_op(decas_pkg::ACT_LOAD_B, 4'd12, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_B, 4'd3, 1'b0);
        queue_op(decas_pkg::ACT_SUB, 4'd0, 1'b0);
        // 001 - 50: longer operand with leading zeros, borrow out of the top
        queue_op(decas_pkg::ACT_LOAD_A, 4'd0, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_A, 4'd0, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_A, 4'd1, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_B, 4'd5, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_B, 4'd0, 1'b0);
        queue_op(decas_pkg::ACT_SUB, 4'd0, 1'b0);
        // equal lengths decided on the low digit: 45 - 47
        queue_op(decas_pkg::ACT_LOAD_A, 4'd4, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_A, 4'd5, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_B, 4'd4, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_B, 4'd7, 1'b0);
        queue_op(decas_pkg::ACT_SUB, 4'd0, 1'b0);
        // carry ripples into a new top digit: 99 + 1
        queue_op(decas_pkg::ACT_LOAD_A, 4'd9, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_A, 4'd9, 1'b0);
        queue_op(decas_pkg::ACT_LOAD_B, 4'd1, 1'b0);
        queue_op(decas_pkg::ACT_ADD, 4'd0, 1'b0);
        // first store overfilled, sent only after all answers so far are back
        for (k = 0; k < decas_pkg::MAX_DIGITS + 2; k++)
            queue_op(decas_pkg::ACT_LOAD_A, rand_digit(), k == 0);
        queue_op(decas_pkg::ACT_LOAD_B, 4'd7, 1'b0);
        queue_op(decas_pkg::ACT_ADD, 4'd0, 1'b0);
        directed_items = action_q.size();

        // random problems, some of them waiting for the block to drain first
        k = 0;
        while (action_q.size() < directed_items + RANDOM_ITEMS)
        begin
            queue_random_problem(k == 0 || $urandom_range(7) == 0);
            k++;
        end
        items_total = action_q.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_sent < items_total)
            @(posedge clk);
        while (answer_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d transactions, checked %0d answer digits", items_sent, results_seen);
        $display("%0d adds, %0d subtracts (%0d negative), %0d computes with dropped digits",
                 adds_done, subs_done, negatives_seen, overflow_computes);
        if (fail_count == 0)
            $display("decimal_add_subtract_core test passed");
        else
            $display("decimal_add_subtract_core test failed");
        $finish;
    end

endmodule
